>>> rtl/core/osr_pkg.sv
package osr_pkg;

  localparam int MAX_ROW_LENGTH = 1024;
  localparam int MAX_SPREAD     = 8;
  localparam int RING_ROWS      = MAX_SPREAD - 1;

  localparam int COL_W    = $clog2(MAX_ROW_LENGTH);
  localparam int LEN_W    = 11;
  localparam int SPREAD_W = 4;
  localparam int SLOT_W   = $clog2(RING_ROWS);
  localparam int ROW_W    = 16;
  localparam int LABEL_W  = 8;
  localparam int RESP_W   = 3;
  localparam int NUM_ORIENT = 8;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [SPREAD_W-1:0] SPREAD_RST  = SPREAD_W'(4);
  localparam logic [LEN_W-1:0]    ROW_LEN_RST = LEN_W'(640);

  typedef enum logic {
    REG_SPREAD_SIZE = 1'b0,
    REG_ROW_LENGTH  = 1'b1
  } reg_idx_e;

  localparam logic [RESP_W-1:0] SIM_ROM [256] = '{
    3'd0, 3'd4, 3'd1, 3'd4, 3'd0, 3'd4, 3'd1, 3'd4, 3'd0, 3'd4, 3'd1, 3'd4, 3'd0, 3'd4, 3'd1, 3'd4,
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd0, 3'd1, 3'd4, 3'd4, 3'd1, 3'd1, 3'd4, 3'd4, 3'd0, 3'd1, 3'd4, 3'd4, 3'd1, 3'd1, 3'd4, 3'd4,
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
    3'd0, 3'd0, 3'd1, 3'd1, 3'd4, 3'd4, 3'd4, 3'd4, 3'd1, 3'd1, 3'd1, 3'd1, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
    3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1,
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd0, 3'd4, 3'd1, 3'd4, 3'd0, 3'd4, 3'd1, 3'd4, 3'd0, 3'd4, 3'd1, 3'd4, 3'd0, 3'd4, 3'd1, 3'd4,
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
    3'd0, 3'd1, 3'd4, 3'd4, 3'd1, 3'd1, 3'd4, 3'd4, 3'd0, 3'd1, 3'd4, 3'd4, 3'd1, 3'd1, 3'd4, 3'd4,
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
    3'd0, 3'd0, 3'd1, 3'd1, 3'd4, 3'd4, 3'd4, 3'd4, 3'd1, 3'd1, 3'd1, 3'd1, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1,
    3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4
  };

  function automatic logic [RESP_W-1:0] sim_response(logic [2:0] orient,
                                                      logic [LABEL_W-1:0] bits);
    logic [RESP_W-1:0] lo;
    logic [RESP_W-1:0] hi;
    lo = SIM_ROM[{orient, 1'b0, bits[3:0]}];
    hi = SIM_ROM[{orient, 1'b1, bits[7:4]}];
    return (lo > hi) ? lo : hi;
  endfunction

endpackage

>>> rtl/core/osr_pix_if.sv
interface osr_pix_if;
  logic                        valid;
  logic                        ready;
  logic [osr_pkg::LABEL_W-1:0] label_bits;
  logic                        frame_end;

  modport source (output valid, output label_bits, output frame_end, input ready);
  modport sink   (input valid, input label_bits, input frame_end, output ready);
endinterface

>>> rtl/core/osr_res_if.sv
interface osr_res_if;
  logic                        valid;
  logic                        ready;
  logic                        out_valid;
  logic [osr_pkg::LABEL_W-1:0] spread_bits;
  logic [osr_pkg::RESP_W-1:0]  response_0;
  logic [osr_pkg::RESP_W-1:0]  response_1;
  logic [osr_pkg::RESP_W-1:0]  response_2;
  logic [osr_pkg::RESP_W-1:0]  response_3;
  logic [osr_pkg::RESP_W-1:0]  response_4;
  logic [osr_pkg::RESP_W-1:0]  response_5;
  logic [osr_pkg::RESP_W-1:0]  response_6;
  logic [osr_pkg::RESP_W-1:0]  response_7;
  logic                        frame_last;

  modport source (
    output valid, output out_valid, output spread_bits,
    output response_0, output response_1, output response_2, output response_3,
    output response_4, output response_5, output response_6, output response_7,
    output frame_last, input ready
  );
  modport sink (
    input valid, input out_valid, input spread_bits,
    input response_0, input response_1, input response_2, input response_3,
    input response_4, input response_5, input response_6, input response_7,
    input frame_last, output ready
  );
endinterface

>>> rtl/core/orientation_spread_and_response.sv
// Channel   Dir  Handshake      Payload
// pix_i     in   valid/ready    label_bits, frame_end
// res_o     out  valid/ready    out_valid, spread_bits, response_0..7, frame_last
// apb       in   psel/penable   paddr, pwdata (0x0 spread_size, 0x4 row_length)
//
// One item per cycle sustained while the output is not stalled; each item is taken into the
// stage-1 and line-store read registers, then its result enters the output register when free.
// The line store has seven row banks, read and written at the accept edge,
// with registered read data feeding the window OR and the response ROM.
// Reset clears counters, column window and pipeline valids; line store contents stay undefined.
// A stalled output holds its result while one more item can enter the middle stage.
module orientation_spread_and_response (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  osr_pix_if.sink                      pix_i,
  osr_res_if.source                    res_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [osr_pkg::ADDR_W-1:0]   paddr,
  input  logic [osr_pkg::DATA_W-1:0]   pwdata,
  output logic [osr_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  localparam int COL_W    = osr_pkg::COL_W;
  localparam int LEN_W    = osr_pkg::LEN_W;
  localparam int SPREAD_W = osr_pkg::SPREAD_W;
  localparam int SLOT_W   = osr_pkg::SLOT_W;
  localparam int ROW_W    = osr_pkg::ROW_W;
  localparam int LABEL_W  = osr_pkg::LABEL_W;
  localparam int RESP_W   = osr_pkg::RESP_W;
  localparam int RING     = osr_pkg::RING_ROWS;
  localparam int NORIENT  = osr_pkg::NUM_ORIENT;

  // configuration
  logic [SPREAD_W-1:0] spread_q;
  logic [LEN_W-1:0]    len_q;
  logic                cfg_wr;
  osr_pkg::reg_idx_e   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = osr_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spread_q <= osr_pkg::SPREAD_RST;
      len_q    <= osr_pkg::ROW_LEN_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        osr_pkg::REG_SPREAD_SIZE: spread_q <= pwdata[SPREAD_W-1:0];
        osr_pkg::REG_ROW_LENGTH:  len_q    <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      osr_pkg::REG_SPREAD_SIZE: prdata = osr_pkg::DATA_W'(spread_q);
      osr_pkg::REG_ROW_LENGTH:  prdata = osr_pkg::DATA_W'(len_q);
      default:                  prdata = '0;
    endcase
  end

  logic [SPREAD_W-1:0] spread_eff;
  logic [LEN_W-1:0]    len_eff;

  always_comb begin
    if (spread_q == '0) spread_eff = SPREAD_W'(1);
    else if (spread_q > SPREAD_W'(osr_pkg::MAX_SPREAD)) spread_eff = SPREAD_W'(osr_pkg::MAX_SPREAD);
    else spread_eff = spread_q;
    if (len_q == '0) len_eff = LEN_W'(1);
    else if (len_q > LEN_W'(osr_pkg::MAX_ROW_LENGTH)) len_eff = LEN_W'(osr_pkg::MAX_ROW_LENGTH);
    else len_eff = len_q;
  end

  // handshake
  logic res_valid_q;
  logic s1_valid_q;
  logic out_free;
  logic in_ready;
  logic acc_in;

  assign out_free    = !res_valid_q || res_o.ready;
  assign in_ready    = !s1_valid_q || out_free;
  assign pix_i.ready = in_ready;
  assign acc_in      = pix_i.valid && in_ready;

  // stage 0: position tracking and horizontal OR
  logic [COL_W-1:0]   col_cnt_q;
  logic [ROW_W-1:0]   row_cnt_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [LABEL_W-1:0] colwin_q [RING];

  logic [COL_W-1:0]   col;
  logic [LABEL_W-1:0] hor;
  logic               row_end;
  logic               win_ok;

  always_comb begin
    if ({1'b0, col_cnt_q} >= len_eff) col = COL_W'(len_eff - LEN_W'(1));
    else col = col_cnt_q;
    hor = pix_i.label_bits;
    for (int k = 0; k < RING; k++) begin
      if (SPREAD_W'(k + 1) < spread_eff) hor = hor | colwin_q[k];
    end
    row_end = ({1'b0, col} + LEN_W'(1)) >= len_eff;
    win_ok  = (({1'b0, row_cnt_q} + (ROW_W+1)'(1)) >= (ROW_W+1)'(spread_eff))
           && (({1'b0, col} + LEN_W'(1)) >= LEN_W'(spread_eff));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
      slot_q    <= '0;
      for (int k = 0; k < RING; k++) colwin_q[k] <= '0;
    end else if (acc_in) begin
      if (pix_i.frame_end) begin
        col_cnt_q <= '0;
        row_cnt_q <= '0;
        slot_q    <= '0;
        for (int k = 0; k < RING; k++) colwin_q[k] <= '0;
      end else if (row_end) begin
        col_cnt_q <= '0;
        if (row_cnt_q != '1) row_cnt_q <= row_cnt_q + ROW_W'(1);
        slot_q <= (slot_q == SLOT_W'(RING - 1)) ? '0 : slot_q + SLOT_W'(1);
        for (int k = 0; k < RING; k++) colwin_q[k] <= '0;
      end else begin
        col_cnt_q   <= col + COL_W'(1);
        colwin_q[0] <= pix_i.label_bits;
        for (int k = 1; k < RING; k++) colwin_q[k] <= colwin_q[k-1];
      end
    end
  end

  // line store: one bank per ring row, read-first
  logic [RING-1:0][LABEL_W-1:0] bank_rd;

  for (genvar b = 0; b < RING; b++) begin : g_bank
    logic [LABEL_W-1:0] mem [osr_pkg::MAX_ROW_LENGTH];
    logic [LABEL_W-1:0] rd_q;
    always_ff @(posedge clk_i) begin
      if (acc_in) begin
        rd_q <= mem[col];
        if (slot_q == SLOT_W'(b)) mem[col] <= hor;
      end
    end
    assign bank_rd[b] = rd_q;
  end

  // stage 1
  logic [LABEL_W-1:0] hor1_q;
  logic [SLOT_W-1:0]  slot1_q;
  logic               ok1_q;
  logic               fend1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_valid_q <= 1'b0;
    else if (in_ready) s1_valid_q <= acc_in;
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      hor1_q  <= hor;
      slot1_q <= slot_q;
      ok1_q   <= win_ok;
      fend1_q <= pix_i.frame_end;
    end
  end

  logic [LABEL_W-1:0] acc1;
  logic [SLOT_W-1:0]  idx;

  always_comb begin
    acc1 = hor1_q;
    idx  = '0;
    for (int k = 1; k <= RING; k++) begin
      if (slot1_q >= SLOT_W'(k)) idx = slot1_q - SLOT_W'(k);
      else idx = SLOT_W'(slot1_q + SLOT_W'(RING - k));
      if (SPREAD_W'(k) < spread_eff) acc1 = acc1 | bank_rd[idx];
    end
  end

  // stage 2: result register
  logic                            ok_q;
  logic [LABEL_W-1:0]              spread_bits_q;
  logic [NORIENT-1:0][RESP_W-1:0]  resp_q;
  logic                            fend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_valid_q <= 1'b0;
    else if (out_free) res_valid_q <= s1_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && out_free) begin
      ok_q          <= ok1_q;
      spread_bits_q <= ok1_q ? acc1 : '0;
      fend_q        <= fend1_q;
      for (int j = 0; j < NORIENT; j++) begin
        resp_q[j] <= ok1_q ? osr_pkg::sim_response(3'(j), acc1) : '0;
      end
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.out_valid   = ok_q;
  assign res_o.spread_bits = spread_bits_q;
  assign res_o.response_0  = resp_q[0];
  assign res_o.response_1  = resp_q[1];
  assign res_o.response_2  = resp_q[2];
  assign res_o.response_3  = resp_q[3];
  assign res_o.response_4  = resp_q[4];
  assign res_o.response_5  = resp_q[5];
  assign res_o.response_6  = resp_q[6];
  assign res_o.response_7  = resp_q[7];
  assign res_o.frame_last  = fend_q;

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.out_valid |-> res_o.spread_bits == '0 && res_o.response_0 == '0)
    else $error("invalid window result carries nonzero payload");

  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && res_o.valid && !res_o.ready |-> !pix_i.ready)
    else $error("input taken while pipeline is full");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SLOT_W'(RING - 1))
    else $error("ring slot out of range");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_in && pix_i.frame_end |=> col_cnt_q == '0 && row_cnt_q == '0 && slot_q == '0)
    else $error("frame end did not restart position");

  a_resp_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_o.response_0 == 3'd0 || res_o.response_0 == 3'd1
                 || res_o.response_0 == 3'd4)
    else $error("response code out of set");
`endif

endmodule

>>> bench/orientation_spread_and_response_tb.sv
`timescale 1ns / 100ps

module orientation_spread_and_response_tb;

  localparam int ROW_W          = osr_pkg::ROW_W;
  localparam int LABEL_W        = osr_pkg::LABEL_W;
  localparam int NUM_ORIENT     = osr_pkg::NUM_ORIENT;
  localparam int RESP_W         = osr_pkg::RESP_W;
  localparam int ADDR_W         = osr_pkg::ADDR_W;
  localparam int DATA_W         = osr_pkg::DATA_W;
  localparam int SPREAD_W       = osr_pkg::SPREAD_W;
  localparam int LEN_W          = osr_pkg::LEN_W;
  localparam int RING_ROWS      = osr_pkg::RING_ROWS;
  localparam int MAX_ROW_LENGTH = osr_pkg::MAX_ROW_LENGTH;
  localparam int MAX_SPREAD     = osr_pkg::MAX_SPREAD;

  localparam int ROW_MAX = (1 << ROW_W) - 1;

  typedef struct packed {
    logic                              full;
    logic [LABEL_W-1:0]                spread;
    logic [NUM_ORIENT-1:0][RESP_W-1:0] score;
    logic                              last;
  } window_result_t;

  typedef enum int {
    LBL_SPARSE,
    LBL_MIXED,
    LBL_DENSE
  } label_mix_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  osr_pix_if pix_if();
  osr_res_if res_if();

  orientation_spread_and_response dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [SPREAD_W-1:0] spread_cfg;
  logic [LEN_W-1:0]    length_cfg;
  logic [LABEL_W-1:0]  line_mem [RING_ROWS][MAX_ROW_LENGTH];
  logic [LABEL_W-1:0]  run_window [MAX_SPREAD];
  int                  col_pos;
  int                  row_pos;
  int                  slot_pos;

  window_result_t pending_windows[$];
  window_result_t seen_window;
  window_result_t want_window;
  bit             idle_on;
  int unsigned    mismatch_count;
  int unsigned    stall_left;
  int unsigned    stall_draw;
  int             orient;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int window_side();
    if (spread_cfg == '0) return 1;
    if (spread_cfg > MAX_SPREAD) return MAX_SPREAD;
    return int'(spread_cfg);
  endfunction

  function automatic int line_length();
    if (length_cfg == '0) return 1;
    if (length_cfg > MAX_ROW_LENGTH) return MAX_ROW_LENGTH;
    return int'(length_cfg);
  endfunction

  function automatic logic [RESP_W-1:0] orientation_score(logic [LABEL_W-1:0] bits, int j);
    if (bits[j]) return RESP_W'(4);
    if (bits[(j + 1) % NUM_ORIENT] || bits[(j + NUM_ORIENT - 1) % NUM_ORIENT]) return RESP_W'(1);
    return '0;
  endfunction

  function automatic window_result_t advance_window(logic [LABEL_W-1:0] label, logic fend);
    int             side;
    int             len;
    int             c;
    int             k;
    int             slot;
    logic [LABEL_W-1:0] hor;
    logic [LABEL_W-1:0] acc;
    window_result_t r;
    side = window_side();
    len = line_length();
    c = (col_pos >= len) ? len - 1 : col_pos;
    if (slot_pos >= RING_ROWS) slot_pos = 0;
    hor = label;
    for (k = 0; k + 1 < side; k++) hor |= run_window[k];
    acc = hor;
    for (k = 1; k < side; k++) begin
      slot = (slot_pos + RING_ROWS - k) % RING_ROWS;
      acc |= line_mem[slot][c];
    end
    line_mem[slot_pos][c] = hor;
    for (k = MAX_SPREAD - 1; k > 0; k--) run_window[k] = run_window[k-1];
    run_window[0] = label;
    r.full = (row_pos + 1 >= side) && (c + 1 >= side);
    r.spread = r.full ? acc : '0;
    for (k = 0; k < NUM_ORIENT; k++) r.score[k] = r.full ? orientation_score(acc, k) : '0;
    r.last = fend;
    if (fend) begin
      col_pos = 0;
      row_pos = 0;
      slot_pos = 0;
      for (k = 0; k < MAX_SPREAD; k++) run_window[k] = '0;
    end else if (c + 1 >= len) begin
      col_pos = 0;
      if (row_pos < ROW_MAX) row_pos++;
      slot_pos = (slot_pos + 1) % RING_ROWS;
      for (k = 0; k < MAX_SPREAD; k++) run_window[k] = '0;
    end else begin
      col_pos = c + 1;
    end
    return r;
  endfunction

  function automatic void flag_mismatch(string field, logic [DATA_W-1:0] want_v,
                                        logic [DATA_W-1:0] got_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %0s at %0t: expected %0h, got %0h", field, $time, want_v, got_v);
  endfunction

  function automatic logic [LABEL_W-1:0] pick_label(label_mix_e mix);
    int unsigned roll;
    roll = $urandom_range(0, 15);
    case (mix)
      LBL_SPARSE: begin
        if (roll == 0) return LABEL_W'(1) << $urandom_range(0, NUM_ORIENT - 1);
        return '0;
      end
      LBL_MIXED: begin
        if (roll < 8) return LABEL_W'(1) << $urandom_range(0, NUM_ORIENT - 1);
        if (roll < 12) return '0;
        return LABEL_W'($urandom);
      end
      default: return LABEL_W'($urandom);
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_left <= 0;
    end else if (res_if.valid && res_if.ready) begin
      seen_window.full = res_if.out_valid;
      seen_window.spread = res_if.spread_bits;
      seen_window.score = {res_if.response_7, res_if.response_6, res_if.response_5,
                           res_if.response_4, res_if.response_3, res_if.response_2,
                           res_if.response_1, res_if.response_0};
      seen_window.last = res_if.frame_last;
      if (pending_windows.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result at %0t: spread_bits %0h", $time, seen_window.spread);
      end else begin
        want_window = pending_windows.pop_front();
        if (seen_window.full !== want_window.full)
          flag_mismatch("out_valid", want_window.full, seen_window.full);
        if (seen_window.spread !== want_window.spread)
          flag_mismatch("spread_bits", want_window.spread, seen_window.spread);
        for (orient = 0; orient < NUM_ORIENT; orient++)
          if (seen_window.score[orient] !== want_window.score[orient])
            flag_mismatch($sformatf("response_%0d", orient), want_window.score[orient],
                          seen_window.score[orient]);
        if (seen_window.last !== want_window.last)
          flag_mismatch("frame_last", want_window.last, seen_window.last);
      end
      stall_draw = idle_on ? $urandom_range(0, 15) : 0;
      res_if.ready <= (stall_draw == 0);
      stall_left <= (stall_draw == 0) ? 0 : stall_draw - 1;
    end else if (!res_if.ready) begin
      if (stall_left == 0) res_if.ready <= 1'b1;
      else stall_left <= stall_left - 1;
    end
  end

  task automatic send_pixel(input logic [LABEL_W-1:0] label, input logic fend);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.label_bits <= label;
    pix_if.frame_end <= fend;
    do @(posedge clk_i); while (!pix_if.ready);
    pending_windows.push_back(advance_window(label, fend));
  endtask

  task automatic send_frame(input int unsigned count, input label_mix_e mix);
    for (int unsigned i = 0; i < count; i++) send_pixel(pick_label(mix), i == count - 1);
  endtask

  task automatic drain_results();
    pix_if.valid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input osr_pkg::reg_idx_e idx,
                            input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_register(input osr_pkg::reg_idx_e idx, input logic [DATA_W-1:0] want);
    logic [DATA_W-1:0] readback;
    apb_access(1'b0, idx, '0, readback);
    if (readback !== want) flag_mismatch(idx.name(), want, readback);
  endtask

  task automatic set_register(input osr_pkg::reg_idx_e idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] unused;
    drain_results();
    apb_access(1'b1, idx, value, unused);
    if (idx == osr_pkg::REG_SPREAD_SIZE) begin
      spread_cfg = value[SPREAD_W-1:0];
      check_register(idx, DATA_W'(spread_cfg));
    end else begin
      length_cfg = value[LEN_W-1:0];
      check_register(idx, DATA_W'(length_cfg));
    end
  endtask

  task automatic test_register_reset();
    check_register(osr_pkg::REG_SPREAD_SIZE, DATA_W'(osr_pkg::SPREAD_RST));
    check_register(osr_pkg::REG_ROW_LENGTH, DATA_W'(osr_pkg::ROW_LEN_RST));
  endtask

  task automatic test_label_extremes();
    logic [LABEL_W-1:0] labels [9];
    labels = '{8'h00, 8'h80, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40};
    set_register(osr_pkg::REG_SPREAD_SIZE, 2);
    set_register(osr_pkg::REG_ROW_LENGTH, 3);
    idle_on = 1'b1;
    for (int i = 0; i < 9; i++) send_pixel(labels[i], i == 8);
  endtask

  task automatic test_size_clamps();
    logic [LABEL_W-1:0] labels [6];
    labels = '{8'hFF, 8'h00, 8'h81, 8'h18, 8'h5A, 8'hA5};
    set_register(osr_pkg::REG_SPREAD_SIZE, 0);
    set_register(osr_pkg::REG_ROW_LENGTH, 0);
    for (int i = 0; i < 6; i++) send_pixel(labels[i], i == 5);
  endtask

  task automatic test_frame_cut();
    set_register(osr_pkg::REG_SPREAD_SIZE, 3);
    set_register(osr_pkg::REG_ROW_LENGTH, 4);
    send_frame(11, LBL_DENSE);
  endtask

  task automatic test_largest_window();
    set_register(osr_pkg::REG_SPREAD_SIZE, 15);
    set_register(osr_pkg::REG_ROW_LENGTH, 10);
    idle_on = 1'b0;
    send_frame(11 * 10, LBL_MIXED);
  endtask

  task automatic test_many_rows();
    set_register(osr_pkg::REG_SPREAD_SIZE, 2);
    set_register(osr_pkg::REG_ROW_LENGTH, 2);
    idle_on = 1'b0;
    send_frame(2 * 30, LBL_DENSE);
  endtask

  task automatic test_random_frames();
    int unsigned sent;
    int unsigned frame_len;
    for (int phase = 0; phase < 8; phase++) begin
      set_register(osr_pkg::REG_SPREAD_SIZE,
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                               : $urandom_range(1, MAX_SPREAD));
      set_register(osr_pkg::REG_ROW_LENGTH,
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40)
                                               : $urandom_range(1, 12));
      idle_on = ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < 40) begin
        frame_len = (window_side() + $urandom_range(0, 2)) * line_length();
        if ($urandom_range(0, 4) == 0) frame_len = $urandom_range(1, frame_len);
        send_frame(frame_len, label_mix_e'($urandom_range(0, 2)));
        sent += frame_len;
        // hold the stream until the block has emptied
        if (phase == 2) drain_results();
      end
    end
  endtask

  initial begin
    pix_if.valid <= 1'b0;
    pix_if.label_bits <= '0;
    pix_if.frame_end <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    spread_cfg = osr_pkg::SPREAD_RST;
    length_cfg = osr_pkg::ROW_LEN_RST;
    for (int r = 0; r < RING_ROWS; r++)
      for (int c = 0; c < MAX_ROW_LENGTH; c++) line_mem[r][c] = '0;
    for (int k = 0; k < MAX_SPREAD; k++) run_window[k] = '0;
    col_pos = 0;
    row_pos = 0;
    slot_pos = 0;
    idle_on = 1'b1;
    mismatch_count = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_reset();
    test_label_extremes();
    test_size_clamps();
    test_frame_cut();
    test_largest_window();
    test_many_rows();
    test_random_frames();

    drain_results();
    if (mismatch_count == 0 && pending_windows.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/osr_pkg.sv
rtl/core/osr_pix_if.sv
rtl/core/osr_res_if.sv
rtl/core/orientation_spread_and_response.sv
bench/orientation_spread_and_response_tb.sv
